>>> rtl/core/ambiguous_codon_translator_top_macros.svh
// Assertion macros shared by the ambiguous codon translator RTL.
`ifndef AMBIGUOUS_CODON_TRANSLATOR_TOP_MACROS_SVH
`define AMBIGUOUS_CODON_TRANSLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/act_pkg.sv
// Shared types, constants and functions of the ambiguous codon translator.
package act_pkg;

    localparam int unsigned NUM_CODONS = 64;
    localparam int unsigned CODON_W    = 6;
    localparam int unsigned AMINO_W    = 5;
    localparam int unsigned ENTRY_W    = AMINO_W + 1;
    localparam int unsigned NUM_POS    = 3;
    localparam int unsigned NUM_BASES  = 4;
    localparam int unsigned BASE_W     = 2;
    localparam int unsigned MASK_W     = NUM_POS * NUM_BASES;

    localparam logic [AMINO_W-1:0] AMINO_D       = 5'd3;
    localparam logic [AMINO_W-1:0] AMINO_E       = 5'd4;
    localparam logic [AMINO_W-1:0] AMINO_N       = 5'd13;
    localparam logic [AMINO_W-1:0] AMINO_Q       = 5'd16;
    localparam logic [AMINO_W-1:0] AMINO_STOP    = 5'd26;
    localparam logic [AMINO_W-1:0] AMINO_D_OR_N  = 5'd27;
    localparam logic [AMINO_W-1:0] AMINO_E_OR_Q  = 5'd28;
    localparam logic [AMINO_W-1:0] AMINO_UNKNOWN = 5'd29;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } act_op_t;

    // Query token that walks the cell chain, summarizing matches so far
    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic               have1;
        logic [AMINO_W-1:0] aa1;
        logic               have2;
        logic [AMINO_W-1:0] aa2;
        logic               many;
        logic [ENTRY_W-1:0] last;
    } act_tok_t;

    typedef struct packed {
        logic [AMINO_W-1:0] amino_code;
        logic               start_ok;
    } act_res_t;

    // One-hot base pattern of a codon, four bits per position
    function automatic logic [MASK_W-1:0] codon_pattern(input logic [CODON_W-1:0] codon);
        logic [MASK_W-1:0] pat;
        pat = '0;
        for (int p = 0; p < NUM_POS; p++) begin
            pat[NUM_BASES * p + int'(codon[BASE_W * p +: BASE_W])] = 1'b1;
        end
        return pat;
    endfunction

    // Stored amino code: anything past stop becomes unknown
    function automatic logic [AMINO_W-1:0] clamp_amino(input logic [AMINO_W-1:0] aa);
        return (aa > AMINO_STOP) ? AMINO_UNKNOWN : aa;
    endfunction

    // Turn the summary at the end of the chain into a result
    function automatic act_res_t resolve(input act_tok_t tok);
        act_res_t res;
        res.amino_code = AMINO_UNKNOWN;
        res.start_ok   = 1'b0;
        if (!tok.have2) begin
            res.amino_code = tok.last[ENTRY_W-1:1];
            res.start_ok   = tok.last[0];
        end else if (tok.many) begin
            res.amino_code = AMINO_UNKNOWN;
        end else if ((tok.aa1 == AMINO_D && tok.aa2 == AMINO_N) ||
                     (tok.aa1 == AMINO_N && tok.aa2 == AMINO_D)) begin
            res.amino_code = AMINO_D_OR_N;
        end else if ((tok.aa1 == AMINO_E && tok.aa2 == AMINO_Q) ||
                     (tok.aa1 == AMINO_Q && tok.aa2 == AMINO_E)) begin
            res.amino_code = AMINO_E_OR_Q;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/act_if.sv
// Valid/ready channel interfaces for requests and results.
interface act_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [act_pkg::CODON_W-1:0]   codon_index;
    logic [act_pkg::AMINO_W-1:0]   amino_in;
    logic                          start_in;
    logic [act_pkg::MASK_W-1:0]    query_mask;

    modport source (output valid, op, codon_index, amino_in, start_in, query_mask,
                    input ready);
    modport sink   (input valid, op, codon_index, amino_in, start_in, query_mask,
                    output ready);
endinterface

interface act_out_if;
    logic                          valid;
    logic                          ready;
    logic [act_pkg::AMINO_W-1:0]   amino_code;
    logic                          start_ok;

    modport source (output valid, amino_code, start_ok, input ready);
    modport sink   (input valid, amino_code, start_ok, output ready);
endinterface

>>> rtl/core/act_cell.sv
// One codon cell: holds one genetic code entry and folds it into a passing query.
module act_cell #(
    parameter int unsigned CODON      = 0,
    parameter int unsigned NUM_CODONS = act_pkg::NUM_CODONS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         load_en,
    input  logic [$clog2(NUM_CODONS)-1:0] load_idx,
    input  logic [act_pkg::ENTRY_W-1:0]  load_entry,
    input  logic                         valid_in,
    input  act_pkg::act_tok_t            tok_in,
    output logic                         valid_out,
    output act_pkg::act_tok_t            tok_out
);

    localparam int unsigned IDX_W = $clog2(NUM_CODONS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CODON);
    localparam logic [act_pkg::MASK_W-1:0] PAT =
        act_pkg::codon_pattern(act_pkg::CODON_W'(CODON));
    localparam bit IS_FIRST = (CODON == 0);

    logic [act_pkg::ENTRY_W-1:0] entry_reg;
    logic                        valid_reg;
    act_pkg::act_tok_t           tok_reg;
    act_pkg::act_tok_t           tok_next;
    logic [act_pkg::AMINO_W-1:0] aa;
    logic                        match;

    // Write own entry on a load request addressed here
    always_ff @(posedge clk) begin
        if (load_en && load_idx == MY_IDX)
        begin
            entry_reg <= load_entry;
        end
    end

    // Fold this codon into the query summary
    always_comb
    begin
        aa       = entry_reg[act_pkg::ENTRY_W-1:1];
        match    = ((PAT & tok_in.mask) == PAT);
        tok_next = tok_in;
        if (match)
        begin
            if (!tok_in.have1)
            begin
                tok_next.have1 = 1'b1;
                tok_next.aa1   = aa;
            end else if (aa != tok_in.aa1)
            begin
                if (!tok_in.have2)
                begin
                    tok_next.have2 = 1'b1;
                    tok_next.aa2   = aa;
                end else if (aa != tok_in.aa2)
                begin
                    tok_next.many = 1'b1;
                end
            end
        end
        // Codon 0 seeds the fallback entry for a query with no match
        if (match || IS_FIRST)
        begin
            tok_next.last = entry_reg;
        end
    end

    // Advance the token valid bit
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance the token payload
    always_ff @(posedge clk) begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

>>> rtl/core/ambiguous_codon_translator_top.sv
// Top level of the ambiguous codon translator: cell chain, result register, flow control.
// A load request writes one codon entry and gives no result. A query request walks
// a row of NUM_CODONS cells, one cell per cycle unless the output stalls, each cell
// holding one codon entry and folding it into the query's running summary; the result
// is registered after the last cell, and queries stream in at one per cycle unless the
// output stalls. A load is held off until every query in flight has been delivered.
// All entries must be loaded before the first query; the store has no reset and no
// clearing pass.
`include "ambiguous_codon_translator_top_macros.svh"

module ambiguous_codon_translator_top #(
    parameter int unsigned NUM_CODONS = act_pkg::NUM_CODONS
) (
    input  logic       clk,
    input  logic       rst_n,
    act_in_if.sink     request,
    act_out_if.source  result
);

    localparam int unsigned IDX_W = $clog2(NUM_CODONS);
    localparam int unsigned CNT_W = $clog2(NUM_CODONS + 2);
    localparam logic [CNT_W-1:0] MAX_INFLIGHT = CNT_W'(NUM_CODONS + 1);

    logic                          advance;
    logic                          req_acc;
    logic                          load_en;
    logic                          query_en;
    logic                          out_acc;
    logic [act_pkg::ENTRY_W-1:0]   load_entry;
    logic [CNT_W-1:0]              inflight_reg;
    logic [CNT_W-1:0]              inflight_next;
    logic                          out_valid_reg;
    act_pkg::act_res_t             out_res_reg;
    act_pkg::act_res_t             tail_res;
    logic                          valid_chain [NUM_CODONS+1];
    act_pkg::act_tok_t             tok_chain   [NUM_CODONS+1];

    // Stall the whole chain while a result waits at the output
    assign advance  = !out_valid_reg || result.ready;
    assign request.ready = advance &&
        (request.op == act_pkg::OP_QUERY || inflight_reg == '0);
    assign req_acc  = request.valid && request.ready;
    assign load_en  = req_acc && request.op == act_pkg::OP_LOAD;
    assign query_en = req_acc && request.op == act_pkg::OP_QUERY;
    assign out_acc  = out_valid_reg && result.ready;

    assign load_entry = {act_pkg::clamp_amino(request.amino_in), request.start_in};

    // Build an empty summary at the head of the chain
    assign valid_chain[0] = query_en;
    assign tok_chain[0]   = '{mask: request.query_mask, default: '0};

    // Row of codon cells
    for (genvar k = 0; k < NUM_CODONS; k++) begin : g_cell
        act_cell #(
            .CODON      (k),
            .NUM_CODONS (NUM_CODONS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .load_en    (load_en),
            .load_idx   (request.codon_index[IDX_W-1:0]),
            .load_entry (load_entry),
            .valid_in   (valid_chain[k]),
            .tok_in     (tok_chain[k]),
            .valid_out  (valid_chain[k+1]),
            .tok_out    (tok_chain[k+1])
        );
    end

    assign tail_res = act_pkg::resolve(tok_chain[NUM_CODONS]);

    // Count queries between acceptance and delivery
    assign inflight_next = inflight_reg + CNT_W'(query_en) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            inflight_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else
        begin
            inflight_reg <= inflight_next;
            if (advance)
            begin
                out_valid_reg <= valid_chain[NUM_CODONS];
            end
        end
    end

    // Capture the resolved result
    always_ff @(posedge clk) begin
        if (advance)
        begin
            out_res_reg <= tail_res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.amino_code = out_res_reg.amino_code;
    assign result.start_ok   = out_res_reg.start_ok;

    `ACT_ASSERT_NOW(a_load_when_drained, load_en, inflight_reg == '0, "load taken with queries in flight")
    `ACT_ASSERT_NOW(a_inflight_bound, 1'b1, inflight_reg <= MAX_INFLIGHT, "in-flight count overflow")
    `ACT_ASSERT_NOW(a_tail_counted, valid_chain[NUM_CODONS] || out_valid_reg, inflight_reg != '0, "query in chain not counted")
    `ACT_ASSERT_NEXT(a_query_counted, query_en, inflight_reg != '0, "accepted query not counted")

endmodule
